// ===== sv/arc_pkg.sv =====
// Shared types, widths and codes for the auto-range calibrator.
// Depends on nothing; every other file of the block depends on it.
package arc_pkg;

    // field and datapath widths
    localparam int VAL_W      = 16;
    localparam int ACT_W      = 3;
    localparam int MARGIN_W   = 7;
    localparam int LIM_W      = 24;
    localparam int DECAL_W    = 32;
    localparam int A_W        = LIM_W + 1;   // multiplier operand a, also limit span
    localparam int B_W        = VAL_W + 1;   // multiplier operand b
    localparam int PROD_W     = A_W + B_W;   // product and dividend
    localparam int DSR_W      = A_W;         // divisor
    localparam int SUM_W      = PROD_W + 1;  // decal sum before saturation

    localparam int FULL_SCALE_BITS_DEF = 16;

    // margin handling
    localparam logic [MARGIN_W-1:0] MARGIN_MAX   = 7'd98;
    localparam logic [MARGIN_W:0]   PERCENT_FULL = 8'd100;

    // saturation bounds
    localparam logic signed [LIM_W-1:0] S16_MAX   = LIM_W'(32767);
    localparam logic signed [LIM_W-1:0] S16_MIN   = LIM_W'(-32768);
    localparam logic signed [SUM_W-1:0] DECAL_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] DECAL_MIN = SUM_W'(-64'sd2147483648);

    // action codes
    localparam logic [ACT_W-1:0] ACT_SAMPLE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CAL       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SET_LOWER = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_UPPER = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FEEDBACK  = 3'd4;

    // which computation the shared multiplier and divider serve
    typedef enum logic [1:0] {
        OP_LIM,
        OP_SMP,
        OP_FB
    } arc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LIM_MUL,
        ST_LIM_DIV,
        ST_LIM_WAIT,
        ST_SMP_PREP,
        ST_SMP_MUL,
        ST_SMP_DIV,
        ST_SMP_WAIT,
        ST_FB_MUL,
        ST_FB_DIV,
        ST_FB_WAIT,
        ST_FINISH
    } arc_state_t;

    typedef struct packed {
        logic    latch_item;
        logic    decode;
        logic    smp_prep;
        logic    mul_load;
        logic    div_start;
        logic    div_take;
        logic    load_out;
        arc_op_t op_sel;
    } arc_cmd_t;

    typedef struct packed {
        logic need_limits;
        logic is_sample;
        logic fb_changed;
        logic marks_equal;
        logic div_done;
    } arc_stat_t;

endpackage

// ===== sv/arc_item_if.sv =====
// Input channel of the calibrator: valid/ready plus one action item.
// Depends on arc_pkg for field widths.
interface arc_item_if;
    import arc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic                    calibrate_on;

    modport source (output valid, output action, output value, output calibrate_on,
                    input ready);
    modport sink   (input valid, input action, input value, input calibrate_on,
                    output ready);
endinterface

// ===== sv/arc_result_if.sv =====
// Output channel of the calibrator: valid/ready plus one result record.
// Depends on arc_pkg for field widths.
interface arc_result_if;
    import arc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [VAL_W-1:0]          scaled_value;
    logic                      scaled_valid;
    logic signed [DECAL_W-1:0] decal_value;
    logic                      decal_valid;
    logic signed [VAL_W-1:0]   lower_mark;
    logic signed [VAL_W-1:0]   upper_mark;
    logic                      lower_changed;
    logic                      upper_changed;

    modport source (output valid, output scaled_value, output scaled_valid,
                    output decal_value, output decal_valid, output lower_mark,
                    output upper_mark, output lower_changed, output upper_changed,
                    input ready);
    modport sink   (input valid, input scaled_value, input scaled_valid,
                    input decal_value, input decal_valid, input lower_mark,
                    input upper_mark, input lower_changed, input upper_changed,
                    output ready);
endinterface

// ===== sv/arc_div.sv =====
// Serial signed divider, two quotient bits per cycle, truncating toward zero.
// Depends on arc_pkg for default widths.
module arc_div #(
    parameter int DVD_W = arc_pkg::PROD_W,
    parameter int DSR_W = arc_pkg::DSR_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic signed [DSR_W-1:0] divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient
);
    localparam int ITER  = (DVD_W + 1) / 2;
    localparam int Q_W   = 2 * ITER;
    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;

    logic [DVD_W-1:0] dvd_neg;
    logic [DSR_W-1:0] dsr_neg;
    logic [Q_W-1:0]   dvd_mag;
    logic [DSR_W-1:0] dsr_mag;
    logic [DSR_W:0]   trial;
    logic [DSR_W-1:0] rem_v;
    logic [Q_W-1:0]   q_v;
    logic [Q_W-1:0]   q_neg;

    // operand magnitudes
    assign dvd_neg = DVD_W'(-dividend);
    assign dsr_neg = DSR_W'(-divisor);
    assign dvd_mag = Q_W'(dividend[DVD_W-1] ? dvd_neg : $unsigned(dividend));
    assign dsr_mag = divisor[DSR_W-1] ? dsr_neg : $unsigned(divisor);

    // two restoring steps
    always_comb
    begin
        rem_v = rem_reg;
        q_v   = q_reg;
        trial = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem_v, q_v[Q_W-1]};
            q_v   = {q_v[Q_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                trial  = trial - {1'b0, d_reg};
                q_v[0] = 1'b1;
            end
            rem_v = trial[DSR_W-1:0];
        end
    end

    // sequencing
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(ITER - 1);
            q_next   = dvd_mag;
            rem_next = '0;
            d_next   = dsr_mag;
            neg_next = dividend[DVD_W-1] ^ divisor[DSR_W-1];
        end
        else if (run_reg)
        begin
            q_next   = q_v;
            rem_next = rem_v;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // signed result
    assign q_neg    = -q_reg;
    assign quotient = $signed(neg_reg ? q_neg[DVD_W-1:0] : q_reg[DVD_W-1:0]);
    assign done     = done_reg;

    // a new division never starts on top of a running one
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !run_reg)
        else $error("divider started while busy");
    // completion lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

// ===== sv/arc_dp.sv =====
// Calibrator datapath: marks, limits, shared multiplier and divider, result record.
// Depends on arc_pkg and arc_div.
module arc_dp #(
    parameter int FULL_SCALE_BITS = arc_pkg::FULL_SCALE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [arc_pkg::MARGIN_W-1:0]      cfg_wdata,
    input  logic [arc_pkg::ACT_W-1:0]         action,
    input  logic signed [arc_pkg::VAL_W-1:0]  value,
    input  logic                              calibrate_on,
    input  arc_pkg::arc_cmd_t                 cmd,
    output arc_pkg::arc_stat_t                stat,
    output logic [arc_pkg::VAL_W-1:0]         scaled_value,
    output logic                              scaled_valid,
    output logic signed [arc_pkg::DECAL_W-1:0] decal_value,
    output logic                              decal_valid,
    output logic signed [arc_pkg::VAL_W-1:0]  lower_mark,
    output logic signed [arc_pkg::VAL_W-1:0]  upper_mark,
    output logic                              lower_changed,
    output logic                              upper_changed
);
    import arc_pkg::*;

    localparam int MASK_I = (1 << FULL_SCALE_BITS) - 1;
    localparam logic signed [B_W-1:0]    MASK_B = B_W'(MASK_I);
    localparam logic signed [DSR_W-1:0]  MASK_D = DSR_W'(MASK_I);
    localparam logic signed [PROD_W-1:0] MASK_Q = PROD_W'(MASK_I);

    // calibration state
    logic [MARGIN_W-1:0]     margin_reg;
    logic signed [VAL_W-1:0] lower_reg, upper_reg, last_sample_reg, last_fb_reg;
    logic signed [LIM_W-1:0] lower_limit_reg, upper_limit_reg;
    logic                    cal_reg;
    logic signed [DECAL_W-1:0] decal_reg;
    logic                    lc_reg, uc_reg, dv_reg;

    // current transaction and working values
    logic [ACT_W-1:0]         act_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic                     calon_reg;
    logic signed [LIM_W-1:0]  s_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]         scaled_reg;

    // result record
    logic [VAL_W-1:0]          o_scaled_reg;
    logic                      o_sv_reg, o_dv_reg, o_lc_reg, o_uc_reg;
    logic signed [DECAL_W-1:0] o_decal_reg;
    logic signed [VAL_W-1:0]   o_lower_reg, o_upper_reg;

    // decode results
    logic signed [VAL_W-1:0] dec_lower, dec_upper, dec_fb;
    logic                    dec_cal, dec_lc, dec_uc, dec_dv;

    logic [MARGIN_W-1:0]      f_clamp;
    logic signed [A_W-1:0]    ll_x, den, mark_diff;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DSR_W-1:0]  div_d;
    logic signed [PROD_W-1:0] quot;
    logic                     div_done;

    logic signed [LIM_W-1:0]  delta, lim_lo_n, lim_hi_n;
    logic [VAL_W-1:0]         scaled_div;
    logic signed [SUM_W-1:0]  dsum;
    logic signed [DECAL_W-1:0] decal_n;
    logic signed [LIM_W-1:0]  v_x, s_lo, s_cl, s_n;
    logic signed [VAL_W-1:0]  samp_sat;
    logic [VAL_W-1:0]         scaled_eq;

    // action decode against current state
    always_comb
    begin
        dec_lower = lower_reg;
        dec_upper = upper_reg;
        dec_cal   = cal_reg;
        dec_fb    = last_fb_reg;
        dec_lc    = 1'b0;
        dec_uc    = 1'b0;
        dec_dv    = 1'b0;
        case (act_reg)
            ACT_SAMPLE:
            begin
                if (cal_reg)
                begin
                    if (val_reg < lower_reg)
                    begin
                        dec_lower = val_reg;
                        dec_lc    = 1'b1;
                    end
                    if (val_reg > upper_reg)
                    begin
                        dec_upper = val_reg;
                        dec_uc    = 1'b1;
                    end
                end
            end
            ACT_CAL:
            begin
                if (calon_reg != cal_reg)
                begin
                    dec_cal = calon_reg;
                    if (calon_reg)
                    begin
                        dec_lower = last_sample_reg;
                        dec_upper = last_sample_reg;
                        dec_lc    = 1'b1;
                        dec_uc    = 1'b1;
                    end
                end
            end
            ACT_SET_LOWER:
            begin
                if (val_reg != lower_reg)
                begin
                    dec_lower = val_reg;
                    dec_lc    = 1'b1;
                end
            end
            ACT_SET_UPPER:
            begin
                if (val_reg != upper_reg)
                begin
                    dec_upper = val_reg;
                    dec_uc    = 1'b1;
                end
            end
            ACT_FEEDBACK:
            begin
                if (val_reg != last_fb_reg)
                begin
                    dec_fb = val_reg;
                    dec_dv = 1'b1;
                end
            end
            default:
            begin
                dec_lc = 1'b0;
            end
        endcase
    end

    // spans and margin
    assign f_clamp   = (margin_reg > MARGIN_MAX) ? MARGIN_MAX : margin_reg;
    assign ll_x      = A_W'(lower_limit_reg);
    assign den       = A_W'(upper_limit_reg) - ll_x;
    assign mark_diff = A_W'(upper_reg) - A_W'(lower_reg);

    // shared multiplier and divisor select
    always_comb
    begin
        case (cmd.op_sel)
            OP_SMP:
            begin
                mul_a = A_W'(s_reg) - ll_x;
                mul_b = MASK_B;
                div_d = den;
            end
            OP_FB:
            begin
                mul_a = den;
                mul_b = B_W'(val_reg);
                div_d = MASK_D;
            end
            default:
            begin
                mul_a = mark_diff;
                mul_b = $signed(B_W'(f_clamp));
                div_d = $signed(DSR_W'(PERCENT_FULL - {1'b0, f_clamp}));
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    arc_div #(
        .DVD_W (PROD_W),
        .DSR_W (DSR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (quot)
    );

    // quotient consumers
    assign delta    = quot[LIM_W-1:0];
    assign lim_lo_n = LIM_W'(lower_reg) - delta;
    assign lim_hi_n = LIM_W'(upper_reg) + delta;

    always_comb
    begin
        if (den == '0 || quot[PROD_W-1])
            scaled_div = '0;
        else if (quot > MASK_Q)
            scaled_div = MASK_Q[VAL_W-1:0];
        else
            scaled_div = quot[VAL_W-1:0];
    end

    assign dsum = SUM_W'(quot) + SUM_W'(lower_limit_reg);

    always_comb
    begin
        if (dsum > DECAL_MAX)
            decal_n = DECAL_MAX[DECAL_W-1:0];
        else if (dsum < DECAL_MIN)
            decal_n = DECAL_MIN[DECAL_W-1:0];
        else
            decal_n = dsum[DECAL_W-1:0];
    end

    // sample clamp: raise to lower limit, then lower to upper limit
    assign v_x  = LIM_W'(val_reg);
    assign s_lo = (v_x < lower_limit_reg) ? lower_limit_reg : v_x;
    assign s_cl = (s_lo > upper_limit_reg) ? upper_limit_reg : s_lo;
    assign s_n  = (stat.marks_equal || cal_reg) ? v_x : s_cl;

    always_comb
    begin
        if (s_n > S16_MAX)
            samp_sat = S16_MAX[VAL_W-1:0];
        else if (s_n < S16_MIN)
            samp_sat = S16_MIN[VAL_W-1:0];
        else
            samp_sat = s_n[VAL_W-1:0];
    end

    assign scaled_eq = val_reg[VAL_W-1] ? '0 : $unsigned(val_reg);

    // status to the controller
    assign stat.need_limits = dec_lc | dec_uc;
    assign stat.is_sample   = (act_reg == ACT_SAMPLE);
    assign stat.fb_changed  = dec_dv;
    assign stat.marks_equal = (lower_reg == upper_reg);
    assign stat.div_done    = div_done;

    // calibration state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg      <= '0;
            lower_reg       <= '0;
            upper_reg       <= '0;
            lower_limit_reg <= '0;
            upper_limit_reg <= '0;
            last_sample_reg <= '0;
            cal_reg         <= 1'b0;
            last_fb_reg     <= '0;
            decal_reg       <= '0;
            lc_reg          <= 1'b0;
            uc_reg          <= 1'b0;
            dv_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                margin_reg <= cfg_wdata;
            if (cmd.decode)
            begin
                lower_reg   <= dec_lower;
                upper_reg   <= dec_upper;
                cal_reg     <= dec_cal;
                last_fb_reg <= dec_fb;
                lc_reg      <= dec_lc;
                uc_reg      <= dec_uc;
                dv_reg      <= dec_dv;
            end
            if (cmd.smp_prep)
                last_sample_reg <= samp_sat;
            if (cmd.div_take && cmd.op_sel == OP_LIM)
            begin
                lower_limit_reg <= lim_lo_n;
                upper_limit_reg <= lim_hi_n;
            end
            if (cmd.div_take && cmd.op_sel == OP_FB)
                decal_reg <= decal_n;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            act_reg   <= action;
            val_reg   <= value;
            calon_reg <= calibrate_on;
        end
        if (cmd.mul_load)
            prod_reg <= mul_p;
        if (cmd.smp_prep)
        begin
            s_reg      <= s_n;
            scaled_reg <= scaled_eq;
        end
        if (cmd.div_take && cmd.op_sel == OP_SMP)
            scaled_reg <= scaled_div;
        if (cmd.load_out)
        begin
            o_scaled_reg <= stat.is_sample ? scaled_reg : '0;
            o_sv_reg     <= stat.is_sample;
            o_decal_reg  <= decal_reg;
            o_dv_reg     <= dv_reg;
            o_lower_reg  <= lower_reg;
            o_upper_reg  <= upper_reg;
            o_lc_reg     <= lc_reg;
            o_uc_reg     <= uc_reg;
        end
    end

    assign scaled_value  = o_scaled_reg;
    assign scaled_valid  = o_sv_reg;
    assign decal_value   = o_decal_reg;
    assign decal_valid   = o_dv_reg;
    assign lower_mark    = o_lower_reg;
    assign upper_mark    = o_upper_reg;
    assign lower_changed = o_lc_reg;
    assign upper_changed = o_uc_reg;

endmodule

// ===== sv/arc_ctrl.sv =====
// Calibrator controller: sequences decode, limit update, scaling and feedback.
// Depends on arc_pkg; drives the datapath through arc_cmd_t.
module arc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  arc_pkg::arc_stat_t stat,
    output arc_pkg::arc_cmd_t  cmd
);
    import arc_pkg::*;

    arc_state_t state_reg, state_next;
    logic       from_cfg_reg, from_cfg_next;
    logic       result_valid_reg, result_valid_next;

    // next state and commands
    always_comb
    begin
        state_next        = state_reg;
        from_cfg_next     = from_cfg_reg;
        result_valid_next = result_valid_reg && !result_ready;
        cmd               = '0;
        item_ready        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = !cfg_we;
                if (cfg_we)
                begin
                    from_cfg_next = 1'b1;
                    state_next    = ST_LIM_MUL;
                end
                else if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    from_cfg_next  = 1'b0;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.need_limits)
                    state_next = ST_LIM_MUL;
                else if (stat.is_sample)
                    state_next = ST_SMP_PREP;
                else if (stat.fb_changed)
                    state_next = ST_FB_MUL;
                else
                    state_next = ST_FINISH;
            end
            ST_LIM_MUL:
            begin
                cmd.op_sel   = OP_LIM;
                cmd.mul_load = 1'b1;
                state_next   = ST_LIM_DIV;
            end
            ST_LIM_DIV:
            begin
                cmd.op_sel    = OP_LIM;
                cmd.div_start = 1'b1;
                state_next    = ST_LIM_WAIT;
            end
            ST_LIM_WAIT:
            begin
                cmd.op_sel = OP_LIM;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    if (from_cfg_reg)
                        state_next = ST_IDLE;
                    else if (stat.is_sample)
                        state_next = ST_SMP_PREP;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SMP_PREP:
            begin
                cmd.smp_prep = 1'b1;
                state_next   = stat.marks_equal ? ST_FINISH : ST_SMP_MUL;
            end
            ST_SMP_MUL:
            begin
                cmd.op_sel   = OP_SMP;
                cmd.mul_load = 1'b1;
                state_next   = ST_SMP_DIV;
            end
            ST_SMP_DIV:
            begin
                cmd.op_sel    = OP_SMP;
                cmd.div_start = 1'b1;
                state_next    = ST_SMP_WAIT;
            end
            ST_SMP_WAIT:
            begin
                cmd.op_sel = OP_SMP;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FB_MUL:
            begin
                cmd.op_sel   = OP_FB;
                cmd.mul_load = 1'b1;
                state_next   = ST_FB_DIV;
            end
            ST_FB_DIV:
            begin
                cmd.op_sel    = OP_FB;
                cmd.div_start = 1'b1;
                state_next    = ST_FB_WAIT;
            end
            ST_FB_WAIT:
            begin
                cmd.op_sel = OP_FB;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to be free
                if (!result_valid_reg || result_ready)
                begin
                    cmd.load_out      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            from_cfg_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            from_cfg_reg     <= from_cfg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // an accepted transaction is decoded in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");
    // a margin write in idle always triggers a limit update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cfg_we) |=> (state_reg == ST_LIM_MUL))
        else $error("margin write did not start limit update");
    // the result record is only overwritten when free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid_reg || result_ready))
        else $error("pending result overwritten");

endmodule

// ===== sv/auto_range_calibrator_unit.sv =====
// Auto-range calibrator top level: controller, datapath and channel wiring.
// Depends on arc_pkg, arc_item_if, arc_result_if, arc_ctrl and arc_dp.
//
// Usage: each transaction on the item channel carries one action (sample,
// calibrate flag, set lower, set upper, feedback) and yields exactly one
// record on the result channel: scaled sample, decalibrated feedback, both
// marks and their change flags. The user must write margin_percent through
// cfg_we / cfg_wdata only while the block is idle; the block itself does not
// enforce it. The write recomputes the limits, and items are held off while
// that runs. Flow: one item at a time. Control-only actions and samples with
// equal marks bypass the shared divider; a sample or a changed feedback makes
// one pass through it, and an item that moves a mark adds a pass for the limits.
// The result sits in an output register; a stalled receiver does not block
// acceptance of the next item, which waits only when its own record is due.
// Reset clears marks, limits, margin, feedback state and the calibrating
// flag, and leaves the result channel empty.
module auto_range_calibrator_unit #(
    parameter int FULL_SCALE_BITS = arc_pkg::FULL_SCALE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [arc_pkg::MARGIN_W-1:0] cfg_wdata,
    arc_item_if.sink                     item,
    arc_result_if.source                 result
);
    import arc_pkg::*;

    arc_cmd_t  cmd;
    arc_stat_t stat;

    arc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    arc_dp #(
        .FULL_SCALE_BITS (FULL_SCALE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .action        (item.action),
        .value         (item.value),
        .calibrate_on  (item.calibrate_on),
        .cmd           (cmd),
        .stat          (stat),
        .scaled_value  (result.scaled_value),
        .scaled_valid  (result.scaled_valid),
        .decal_value   (result.decal_value),
        .decal_valid   (result.decal_valid),
        .lower_mark    (result.lower_mark),
        .upper_mark    (result.upper_mark),
        .lower_changed (result.lower_changed),
        .upper_changed (result.upper_changed)
    );

endmodule

// ===== sim/arc_calib_check.sv =====
// Result checker for the auto-range calibrator: tracks margin writes and item
// transactions, predicts each result record and compares it with the block's output.
// Depends on arc_pkg, arc_item_if and arc_result_if.
module arc_calib_check
    import arc_pkg::*;
#(
    parameter int FULL_SCALE_BITS = FULL_SCALE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [MARGIN_W-1:0] cfg_wdata,
    arc_item_if                 item,
    arc_result_if               result,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen
);

    localparam longint SCALE_MASK = (longint'(1) << FULL_SCALE_BITS) - 1;
    localparam longint PASS_MAX   = (longint'(1) << VAL_W) - 1;

    typedef struct packed {
        logic [VAL_W-1:0]          scaled;
        logic                      scaled_ok;
        logic signed [DECAL_W-1:0] decal;
        logic                      decal_new;
        logic signed [VAL_W-1:0]   lo;
        logic signed [VAL_W-1:0]   hi;
        logic                      lo_new;
        logic                      hi_new;
    } calib_rec_t;

    // shadow copy of the calibrator state
    logic [MARGIN_W-1:0]       margin_q;
    logic signed [VAL_W-1:0]   lo_mark;
    logic signed [VAL_W-1:0]   hi_mark;
    logic signed [LIM_W-1:0]   lo_lim;
    logic signed [LIM_W-1:0]   hi_lim;
    logic signed [VAL_W-1:0]   prev_sample;
    logic signed [VAL_W-1:0]   prev_fb;
    logic signed [DECAL_W-1:0] decal_q;
    logic                      calibrating;

    calib_rec_t records_due[$];
    calib_rec_t want;
    int         fails;
    int         seen;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // limits = marks widened by span * pct / (100 - pct), pct capped at 98
    function automatic void refresh_limits();
        longint pct;
        longint delta;
        pct = longint'(margin_q);
        if (pct > longint'(MARGIN_MAX))
            pct = longint'(MARGIN_MAX);
        delta = 0;
        if (lo_mark != hi_mark)
            delta = (longint'(hi_mark) - longint'(lo_mark)) * pct
                    / (longint'(PERCENT_FULL) - pct);
        lo_lim = LIM_W'(longint'(lo_mark) - delta);
        hi_lim = LIM_W'(longint'(hi_mark) + delta);
    endfunction

    // apply one action to the shadow state and build its result record
    function automatic calib_rec_t calibrate_item(input logic [ACT_W-1:0] act,
                                                  input logic signed [VAL_W-1:0] val,
                                                  input logic cal);
        calib_rec_t rec;
        longint     s;
        longint     ll;
        longint     ul;
        longint     span;
        longint     scaled;
        longint     d;
        rec    = '0;
        scaled = 0;
        case (act)
            ACT_SAMPLE:
            begin
                s = longint'(val);
                if (calibrating)
                begin
                    if (s < longint'(lo_mark))
                    begin
                        lo_mark = val;
                        refresh_limits();
                        rec.lo_new = 1'b1;
                    end
                    if (s > longint'(hi_mark))
                    begin
                        hi_mark = val;
                        refresh_limits();
                        rec.hi_new = 1'b1;
                    end
                end
                if (lo_mark != hi_mark)
                begin
                    ll   = longint'(lo_lim);
                    ul   = longint'(hi_lim);
                    span = ul - ll;
                    // clamp: raise to the lower limit first, then lower to the upper one
                    if (!calibrating)
                    begin
                        if (s < ll)
                            s = ll;
                        if (s > ul)
                            s = ul;
                    end
                    scaled = (span != 0) ? (s - ll) * SCALE_MASK / span : 0;
                    scaled = clip(scaled, 0, SCALE_MASK);
                end
                else
                    scaled = clip(s, 0, PASS_MAX);
                prev_sample   = VAL_W'(clip(s, longint'(S16_MIN), longint'(S16_MAX)));
                rec.scaled_ok = 1'b1;
            end
            ACT_CAL:
            begin
                if (cal != calibrating)
                begin
                    calibrating = cal;
                    // switching on restarts both marks from the last sample
                    if (cal)
                    begin
                        lo_mark = prev_sample;
                        hi_mark = prev_sample;
                        refresh_limits();
                        rec.lo_new = 1'b1;
                        rec.hi_new = 1'b1;
                    end
                end
            end
            ACT_SET_LOWER:
            begin
                if (val != lo_mark)
                begin
                    lo_mark = val;
                    refresh_limits();
                    rec.lo_new = 1'b1;
                end
            end
            ACT_SET_UPPER:
            begin
                if (val != hi_mark)
                begin
                    hi_mark = val;
                    refresh_limits();
                    rec.hi_new = 1'b1;
                end
            end
            ACT_FEEDBACK:
            begin
                if (val != prev_fb)
                begin
                    prev_fb = val;
                    d = longint'(val) * (longint'(hi_lim) - longint'(lo_lim)) / SCALE_MASK
                        + longint'(lo_lim);
                    decal_q = DECAL_W'(clip(d, longint'(DECAL_MIN), longint'(DECAL_MAX)));
                    rec.decal_new = 1'b1;
                end
            end
            default: ;
        endcase
        rec.scaled = VAL_W'(scaled);
        rec.decal  = decal_q;
        rec.lo     = lo_mark;
        rec.hi     = hi_mark;
        return rec;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            fails++;
        end
    endtask

    // one pass per clock: result transaction, margin write, item transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_q     = '0;
            lo_mark      = '0;
            hi_mark      = '0;
            lo_lim       = '0;
            hi_lim       = '0;
            prev_sample  = '0;
            prev_fb      = '0;
            decal_q      = '0;
            calibrating  = 1'b0;
            fails        = 0;
            seen         = 0;
            records_due.delete();
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen++;
                if (records_due.size() == 0)
                begin
                    $display("%0t: result transaction with no record expected", $time);
                    fails++;
                end
                else
                begin
                    want = records_due.pop_front();
                    check_field("scaled_value", want.scaled, result.scaled_value);
                    check_field("scaled_valid", want.scaled_ok, result.scaled_valid);
                    check_field("decal_value", want.decal, result.decal_value);
                    check_field("decal_valid", want.decal_new, result.decal_valid);
                    check_field("lower_mark", want.lo, result.lower_mark);
                    check_field("upper_mark", want.hi, result.upper_mark);
                    check_field("lower_changed", want.lo_new, result.lower_changed);
                    check_field("upper_changed", want.hi_new, result.upper_changed);
                end
            end
            if (cfg_we)
            begin
                margin_q = cfg_wdata;
                refresh_limits();
            end
            if (item.valid && item.ready)
                records_due.push_back(calibrate_item(item.action, item.value,
                                                     item.calibrate_on));
            fail_count   <= fails;
            pending      <= records_due.size();
            results_seen <= seen;
        end
    end

endmodule

// ===== sim/auto_range_calibrator_unit_tb.sv =====
// Testbench top for auto_range_calibrator_unit: clock, reset, margin writes,
// item stimulus and result back-pressure; checking is done in arc_calib_check.
// Depends on arc_pkg, arc_item_if, arc_result_if, arc_calib_check and the block.
module auto_range_calibrator_unit_tb;
    import arc_pkg::*;

    localparam int     NUM_PHASES  = 8;
    localparam int     PHASE_ITEMS = 150;
    localparam int     HOLD_AFTER  = 200;
    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN_WAIT  = 60;
    localparam longint LIMIT_TIME  = 5_000_000;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

    // action codes the block ignores
    localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [MARGIN_W-1:0] cfg_wdata;

    arc_item_if   item_ch ();
    arc_result_if result_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int items_sent;
    int margin_writes;
    int target;
    bit quiet;

    logic [MARGIN_W-1:0] margin_plan [NUM_PHASES];

    auto_range_calibrator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    arc_calib_check u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item         (item_ch),
        .result       (result_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // 10-unit clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // random 16-bit value weighted toward extremes and small magnitudes
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            4, 5, 6: return VAL_W'($urandom);
            default: return VAL_W'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // value within +-spread of center, saturated to 16 bits
    function automatic logic signed [VAL_W-1:0] jitter(input logic signed [VAL_W-1:0] center,
                                                       input int spread);
        longint v;
        v = longint'(center) + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v < longint'(VAL_MIN))
            v = longint'(VAL_MIN);
        if (v > longint'(VAL_MAX))
            v = longint'(VAL_MAX);
        return VAL_W'(v);
    endfunction

    // offer one item and return at the edge where the transaction completes
    task automatic put_item(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val,
                            input logic cal);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= act;
        item_ch.value        <= val;
        item_ch.calibrate_on <= cal;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (act <= ACT_FEEDBACK)
            items_sent++;
    endtask

    // margin write once every outstanding record has come back
    task automatic write_margin(input logic [MARGIN_W-1:0] m);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        margin_writes++;
    endtask

    // calibrate around a center, then run uncalibrated samples and feedback
    task automatic run_episode();
        logic signed [VAL_W-1:0] center;
        logic signed [VAL_W-1:0] fb;
        int                      spread;
        int                      n;
        center = pick_value();
        spread = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
        if ($urandom_range(0, 1) == 1)
            put_item(ACT_CAL, pick_value(), 1'b0);
        put_item(ACT_CAL, pick_value(), 1'b1);
        n = $urandom_range(2, 12);
        repeat (n) put_item(ACT_SAMPLE, jitter(center, spread), $urandom_range(0, 1));
        put_item(ACT_CAL, pick_value(), 1'b0);
        n = $urandom_range(2, 10);
        repeat (n) put_item(ACT_SAMPLE, jitter(center, 2 * spread + 10), $urandom_range(0, 1));
        // manual marks, possibly inverted
        if ($urandom_range(0, 3) == 0)
        begin
            put_item(ACT_SET_LOWER, jitter(center, spread), $urandom_range(0, 1));
            put_item(ACT_SET_UPPER, jitter(center, spread), $urandom_range(0, 1));
            n = $urandom_range(1, 4);
            repeat (n) put_item(ACT_SAMPLE, jitter(center, 2 * spread + 10), 1'b0);
        end
        // feedback; a kept value repeats the previous one
        fb = pick_value();
        n  = $urandom_range(1, 4);
        repeat (n)
        begin
            if ($urandom_range(0, 3) != 0)
                fb = VAL_W'($urandom_range(0, 65535));
            put_item(ACT_FEEDBACK, fb, $urandom_range(0, 1));
        end
    endtask

    // unstructured items over every action code
    task automatic run_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) put_item(ACT_W'($urandom_range(ACT_SAMPLE, ACT_SPARE_C)), VAL_W'($urandom),
                            $urandom_range(0, 1));
    endtask

    // result receiver: random stalls plus one long hold-off
    initial
    begin : receiver
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                taken++;
            if (!held && taken >= HOLD_AFTER)
            begin
                // the block fills up and has to stall the item channel
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(posedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        #(LIMIT_TIME);
        $display("status: fail");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.action       <= ACT_SAMPLE;
        item_ch.value        <= '0;
        item_ch.calibrate_on <= 1'b0;
        quiet         = 1'b0;
        items_sent    = 0;
        margin_writes = 0;
        margin_plan[0] = 7'd0;
        margin_plan[1] = MARGIN_MAX;
        margin_plan[2] = 7'd127;
        margin_plan[3] = 7'd1;
        margin_plan[4] = 7'd99;
        margin_plan[5] = 7'd50;
        margin_plan[6] = MARGIN_W'($urandom_range(0, 127));
        margin_plan[7] = MARGIN_W'($urandom_range(0, 98));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        write_margin(7'd10);
        // equal marks: pass-through, saturated
        put_item(ACT_SAMPLE, '0, 1'b0);
        put_item(ACT_SAMPLE, VAL_MIN, 1'b1);
        put_item(ACT_SAMPLE, VAL_MAX, 1'b0);
        put_item(ACT_FEEDBACK, '0, 1'b0);
        // widest marks, unchanged mark write
        put_item(ACT_SET_LOWER, VAL_MIN, 1'b0);
        put_item(ACT_SET_UPPER, VAL_MAX, 1'b0);
        put_item(ACT_SET_UPPER, VAL_MAX, 1'b1);
        put_item(ACT_SAMPLE, VAL_MAX, 1'b0);
        put_item(ACT_SAMPLE, VAL_MIN, 1'b0);
        put_item(ACT_FEEDBACK, VAL_MAX, 1'b0);
        put_item(ACT_FEEDBACK, VAL_MIN, 1'b0);
        put_item(ACT_FEEDBACK, VAL_MIN, 1'b1);
        // inverted marks
        put_item(ACT_SET_LOWER, 16'sd1000, 1'b0);
        put_item(ACT_SET_UPPER, -16'sd1000, 1'b0);
        put_item(ACT_SAMPLE, '0, 1'b0);
        put_item(ACT_SAMPLE, 16'sd5000, 1'b0);
        put_item(ACT_SAMPLE, -16'sd5000, 1'b0);
        // calibration on twice, widen, off
        put_item(ACT_CAL, '0, 1'b1);
        put_item(ACT_CAL, VAL_MAX, 1'b1);
        put_item(ACT_SAMPLE, 16'sd200, 1'b0);
        put_item(ACT_SAMPLE, -16'sd300, 1'b0);
        put_item(ACT_CAL, '0, 1'b0);
        put_item(ACT_SAMPLE, 16'sd10000, 1'b1);
        // ignored codes
        put_item(ACT_SPARE_A, VAL_MIN, 1'b1);
        put_item(ACT_SPARE_B, 16'sd1, 1'b0);
        put_item(ACT_SPARE_C, VAL_MAX, 1'b1);

        // random phases, one margin setting each; the last one runs without idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            write_margin(margin_plan[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 3) != 0)
                    run_episode();
                else
                    run_noise();
            end
        end

        // drain
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run covered %0d items and %0d result records over %0d margin settings",
                 items_sent, results_seen, margin_writes);
        $display("including corner values, inverted marks, ignored codes and a long output stall");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
